/* hdl/ip_blocklist_table_unit_assert.svh */
// Assertion macros shared by the blocklist table RTL.
// Expects a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef IP_BLOCKLIST_TABLE_UNIT_ASSERT_SVH
`define IP_BLOCKLIST_TABLE_UNIT_ASSERT_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define IPBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the antecedent implies the consequent in the next cycle.
`define IPBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ipbl_pkg.sv */
// Shared types and constants for the IPv4 blocklist table.
// No dependencies; the table unit and its testbench refer to it.
package ipbl_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ADDR_W  = 32;
    localparam int HITS_W  = 32;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_ACT  = 2'd2
    } t_state;

    typedef struct packed {
        logic [HITS_W-1:0] hits;
        logic [ADDR_W-1:0] addr;
    } t_entry;

endpackage

/* hdl/ipbl_in_if.sv */
// Request channel of the blocklist table: operation and address key.
// Depends on nothing but the valid/ready handshake convention.
interface ipbl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] ip_addr;

    modport source (output valid, output mode, output ip_addr, input ready);
    modport sink   (input valid, input mode, input ip_addr, output ready);
endinterface

/* hdl/ipbl_out_if.sv */
// Response channel of the blocklist table: status and access count.
// Depends on nothing but the valid/ready handshake convention.
interface ipbl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] hit_count;

    modport source (output valid, output status, output hit_count, input ready);
    modport sink   (input valid, input status, input hit_count, output ready);
endinterface

/* hdl/ipbl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the entry store of the blocklist table.
module ipbl_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hdl/ip_blocklist_table_unit.sv */
// IPv4 blocklist table: an exact-match set of up to ipbl_pkg::ENTRIES addresses, each with
// a saturating 32-bit access counter. Every request (lookup, insert, remove) scans the whole
// entry RAM through its single read port, one entry per cycle; in S_ACT the result then goes
// into the output register once that register is free, and the block returns to idle to
// accept the next request. The output register lets a new request start while the previous
// result waits to be taken. Valid bits are flip-flops cleared by reset, so the table is usable
// in the first cycle after reset with no clearing pass.
// Depends on ipbl_pkg, ipbl_in_if, ipbl_out_if, ipbl_ram and the assertion header.
module ip_blocklist_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipbl_in_if.sink     i_in,
    ipbl_out_if.source  o_out
);

    ipbl_pkg::t_state                  r_state, n_state;
    logic [ipbl_pkg::CNT_W-1:0]        r_rd_idx;
    logic                              r_cmp_vld;
    logic [ipbl_pkg::IDX_W-1:0]        r_cmp_idx;
    ipbl_pkg::t_mode                   r_mode;
    logic [ipbl_pkg::ADDR_W-1:0]       r_key;
    logic                              r_found;
    logic [ipbl_pkg::IDX_W-1:0]        r_slot;
    logic [ipbl_pkg::HITS_W-1:0]       r_hits;
    logic                              r_free_found;
    logic [ipbl_pkg::IDX_W-1:0]        r_free;
    logic [ipbl_pkg::ENTRIES-1:0]      r_valid;

    logic                              r_out_valid;
    ipbl_pkg::t_status                 r_out_status;
    logic [ipbl_pkg::HITS_W-1:0]       r_out_hits;

    logic                              in_ready;
    logic                              in_beat;
    logic                              scan_issue;
    logic                              out_free;
    logic                              act_go;

    logic                              mem_we;
    logic [ipbl_pkg::IDX_W-1:0]        mem_waddr;
    ipbl_pkg::t_entry                  mem_wdata;
    ipbl_pkg::t_entry                  mem_rdata;
    logic                              set_valid;
    logic                              clr_valid;
    logic [ipbl_pkg::IDX_W-1:0]        vld_idx;
    ipbl_pkg::t_status                 res_status;
    logic [ipbl_pkg::HITS_W-1:0]       res_hits;
    logic [ipbl_pkg::HITS_W-1:0]       hits_inc;
    logic                              cmp_hit;

    assign in_beat    = i_in.valid && in_ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign scan_issue = (r_state == ipbl_pkg::S_SCAN) &&
                        (r_rd_idx != ipbl_pkg::CNT_W'(ipbl_pkg::ENTRIES));
    assign cmp_hit    = r_valid[r_cmp_idx] && (mem_rdata.addr == r_key);
    assign hits_inc   = (r_hits == '1) ? r_hits : r_hits + ipbl_pkg::HITS_W'(1);

    ipbl_ram #(
        .DEPTH (ipbl_pkg::ENTRIES),
        .WIDTH ($bits(ipbl_pkg::t_entry))
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (scan_issue),
        .i_raddr (r_rd_idx[ipbl_pkg::IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipbl_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = ipbl_pkg::S_SCAN;
                end
            end
            ipbl_pkg::S_SCAN: begin
                if (!scan_issue && !r_cmp_vld) begin
                    n_state = ipbl_pkg::S_ACT;
                end
            end
            ipbl_pkg::S_ACT: begin
                if (out_free) begin
                    n_state = ipbl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ipbl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = (r_state == ipbl_pkg::S_IDLE);
        act_go   = (r_state == ipbl_pkg::S_ACT) && out_free;
    end

    always_comb begin
        res_status = ipbl_pkg::ST_NOT_FOUND;
        res_hits   = '0;
        mem_we     = 1'b0;
        mem_waddr  = r_slot;
        mem_wdata  = '{hits: '0, addr: r_key};
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        vld_idx    = r_slot;
        unique case (r_mode)
            ipbl_pkg::MODE_LOOKUP: begin
                if (r_found) begin
                    res_status     = ipbl_pkg::ST_DONE;
                    res_hits       = hits_inc;
                    mem_we         = act_go;
                    mem_wdata.hits = hits_inc;
                end
            end
            ipbl_pkg::MODE_INSERT: begin
                if (r_found) begin
                    res_status = ipbl_pkg::ST_PRESENT;
                    res_hits   = r_hits;
                end else if (r_free_found) begin
                    res_status = ipbl_pkg::ST_DONE;
                    mem_we     = act_go;
                    mem_waddr  = r_free;
                    set_valid  = act_go;
                    vld_idx    = r_free;
                end else begin
                    res_status = ipbl_pkg::ST_FULL;
                end
            end
            ipbl_pkg::MODE_REMOVE: begin
                if (r_found) begin
                    res_status = ipbl_pkg::ST_DONE;
                    clr_valid  = act_go;
                end
            end
            default: begin
                res_status = ipbl_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipbl_pkg::S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= scan_issue;
            if (set_valid) begin
                r_valid[vld_idx] <= 1'b1;
            end else if (clr_valid) begin
                r_valid[vld_idx] <= 1'b0;
            end
            if (act_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_mode       <= ipbl_pkg::t_mode'(i_in.mode);
            r_key        <= i_in.ip_addr;
            r_rd_idx     <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (scan_issue) begin
                r_rd_idx <= r_rd_idx + ipbl_pkg::CNT_W'(1);
            end
            if (r_cmp_vld) begin
                if (cmp_hit && !r_found) begin
                    r_found <= 1'b1;
                    r_slot  <= r_cmp_idx;
                    r_hits  <= mem_rdata.hits;
                end
                if (!r_valid[r_cmp_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free       <= r_cmp_idx;
                end
            end
        end
        r_cmp_idx <= r_rd_idx[ipbl_pkg::IDX_W-1:0];
        if (act_go) begin
            r_out_status <= res_status;
            r_out_hits   <= res_hits;
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.hit_count = r_out_hits;

`include "ip_blocklist_table_unit_assert.svh"

    `IPBL_ASSERT_NEXT(a_beat_starts_scan, in_beat,
        (r_state == ipbl_pkg::S_SCAN) && (r_rd_idx == '0) && !r_found && !r_free_found,
        "Accepted request did not start a fresh scan.")
    `IPBL_ASSERT_SAME(a_found_is_valid, (r_state == ipbl_pkg::S_ACT) && r_found,
        r_valid[r_slot], "Matched slot is not valid at the end of the scan.")
    `IPBL_ASSERT_SAME(a_no_free_means_full, (r_state == ipbl_pkg::S_ACT) && !r_free_found,
        &r_valid, "Scan found no free slot although the table is not full.")
    `IPBL_ASSERT_SAME(a_ram_write_at_end, mem_we,
        (r_state == ipbl_pkg::S_ACT) && !r_cmp_vld && out_free,
        "Entry RAM written outside the final step of a request.")

endmodule

/* sim/ip_blocklist_table_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for ip_blocklist_table_unit: drives lookup, insert, remove and unused-mode beats and checks
// every response against a mirror of the address table. Depends on ipbl_pkg, ipbl_in_if,
// ipbl_out_if and the block itself.
module ip_blocklist_table_unit_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [ipbl_pkg::HITS_W-1:0] HITS_MAX = '1;
    localparam int POOL_SIZE = ipbl_pkg::ENTRIES + 8;
    localparam int RANDOM_ITEMS = 780;
    localparam int SETTLE_CYCLES = ipbl_pkg::ENTRIES + 16;
    localparam int BACKPRESSURE_CYCLES = 600;

    typedef struct {
        ipbl_pkg::t_status           status;
        logic [ipbl_pkg::HITS_W-1:0] hits;
    } t_reply;

    class blocklist_mirror;
        bit                          valid_q[ipbl_pkg::ENTRIES];
        logic [ipbl_pkg::ADDR_W-1:0] addr_q[ipbl_pkg::ENTRIES];
        logic [ipbl_pkg::HITS_W-1:0] hits_q[ipbl_pkg::ENTRIES];
        t_reply                      expected_replies[$];
        int                          mismatches;

        function new();
            foreach (valid_q[i]) valid_q[i] = 1'b0;
            mismatches = 0;
        endfunction

        function void apply_request(logic [1:0] mode, logic [ipbl_pkg::ADDR_W-1:0] addr);
            int     slot;
            int     spare;
            t_reply r;
            slot = -1;
            spare = -1;
            r.status = ipbl_pkg::ST_NOT_FOUND;
            r.hits = '0;
            for (int i = 0; i < ipbl_pkg::ENTRIES; i++) begin
                if (valid_q[i] && addr_q[i] == addr && slot < 0) slot = i;
                if (!valid_q[i] && spare < 0) spare = i;
            end
            if (mode == ipbl_pkg::MODE_LOOKUP) begin
                if (slot >= 0) begin
                    if (hits_q[slot] != HITS_MAX) hits_q[slot] = hits_q[slot] + 1'b1;
                    r.status = ipbl_pkg::ST_DONE;
                    r.hits = hits_q[slot];
                end
            end else if (mode == ipbl_pkg::MODE_INSERT) begin
                if (slot >= 0) begin
                    r.status = ipbl_pkg::ST_PRESENT;
                    r.hits = hits_q[slot];
                end else if (spare < 0) begin
                    r.status = ipbl_pkg::ST_FULL;
                end else begin
                    valid_q[spare] = 1'b1;
                    addr_q[spare] = addr;
                    hits_q[spare] = '0;
                    r.status = ipbl_pkg::ST_DONE;
                end
            end else if (mode == ipbl_pkg::MODE_REMOVE) begin
                if (slot >= 0) begin
                    valid_q[slot] = 1'b0;
                    r.status = ipbl_pkg::ST_DONE;
                end
            end
            expected_replies.push_back(r);
        endfunction

        function void compare_reply(logic [1:0] status, logic [ipbl_pkg::HITS_W-1:0] hits);
            t_reply r;
            if (expected_replies.size() == 0) begin
                $error("response beat with no request outstanding: status %0d hit_count %0d",
                       status, hits);
                mismatches++;
                return;
            end
            r = expected_replies.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                mismatches++;
            end
            if (hits !== r.hits) begin
                $error("hit_count: expected %0d, actual %0d", r.hits, hits);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm = 1'b0;

    logic [ipbl_pkg::ADDR_W-1:0] pool[POOL_SIZE];
    blocklist_mirror             mirror = new();

    ipbl_in_if  req_if();
    ipbl_out_if rsp_if();

    ip_blocklist_table_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    task automatic offer(input logic [1:0] mode, input logic [ipbl_pkg::ADDR_W-1:0] addr);
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.ip_addr <= addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        mirror.apply_request(mode, addr);
    endtask

    task automatic pause(input int cycles);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        req_if.mode <= 2'($urandom);
        req_if.ip_addr <= $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send(input logic [1:0] mode, input logic [ipbl_pkg::ADDR_W-1:0] addr);
        if (!calm && $urandom_range(99) < 16) pause($urandom_range(1, 90));
        offer(mode, addr);
    endtask

    function automatic logic [ipbl_pkg::ADDR_W-1:0] pick_addr();
        if ($urandom_range(9) == 0) return $urandom;
        return pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic send_random(input int idx);
        int         roll;
        int         ins_pct;
        int         rem_pct;
        logic [1:0] mode;
        if (idx < 260) begin
            ins_pct = 40;
            rem_pct = 10;
        end else if (idx < 520) begin
            ins_pct = 15;
            rem_pct = 45;
        end else begin
            ins_pct = 30;
            rem_pct = 28;
        end
        roll = $urandom_range(99);
        if (roll < 2) mode = MODE_UNUSED;
        else if (roll < 2 + ins_pct) mode = ipbl_pkg::MODE_INSERT;
        else if (roll < 2 + ins_pct + rem_pct) mode = ipbl_pkg::MODE_REMOVE;
        else mode = ipbl_pkg::MODE_LOOKUP;
        send(mode, pick_addr());
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.mode = ipbl_pkg::MODE_LOOKUP;
        req_if.ip_addr = '0;
        pool[0] = '0;
        pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) pool[k] = $urandom;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(ipbl_pkg::MODE_LOOKUP, 32'h0000_0000);
        send(ipbl_pkg::MODE_REMOVE, 32'h0000_0000);
        send(ipbl_pkg::MODE_INSERT, 32'h0000_0000);
        send(ipbl_pkg::MODE_INSERT, 32'hFFFF_FFFF);
        send(ipbl_pkg::MODE_INSERT, 32'h0000_0000);
        send(ipbl_pkg::MODE_LOOKUP, 32'h0000_0000);
        send(ipbl_pkg::MODE_LOOKUP, 32'h0000_0000);
        send(ipbl_pkg::MODE_INSERT, 32'h0000_0000);
        send(ipbl_pkg::MODE_LOOKUP, 32'hFFFF_FFFF);
        send(MODE_UNUSED, 32'h0000_0000);
        send(MODE_UNUSED, 32'h1234_5678);
        send(ipbl_pkg::MODE_LOOKUP, 32'h0000_0000);
        send(ipbl_pkg::MODE_REMOVE, 32'h0000_0000);
        send(ipbl_pkg::MODE_REMOVE, 32'h0000_0000);
        send(ipbl_pkg::MODE_LOOKUP, 32'h0000_0000);
        send(ipbl_pkg::MODE_INSERT, 32'h0000_0000);
        send(ipbl_pkg::MODE_LOOKUP, 32'h0000_0000);
        send(ipbl_pkg::MODE_LOOKUP, 32'hA5A5_5A5A);
        send(ipbl_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
        send(ipbl_pkg::MODE_REMOVE, 32'h0000_0000);

        // Fill the table past capacity so that the last inserts are rejected as full.
        for (int k = 0; k < POOL_SIZE; k++) send(ipbl_pkg::MODE_INSERT, pool[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 400 && n < 550);
            send_random(n);
        end
        calm = 1'b0;
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        while (mirror.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mirror.mismatches == 0) begin
            $display("ip_blocklist_table_unit_tb: clean");
        end else begin
            $display("ip_blocklist_table_unit_tb: errors");
        end
        $finish;
    end

    // The response side stalls at random, and once holds off long enough to back up the block.
    initial begin
        int hold;
        int replies;
        bit pressed;
        hold = 0;
        replies = 0;
        pressed = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else if (!pressed && replies >= 200) begin
                pressed = 1'b1;
                hold = BACKPRESSURE_CYCLES;
                rsp_if.ready <= 1'b0;
            end else if (calm) begin
                rsp_if.ready <= 1'b1;
            end else if ($urandom_range(199) == 0) begin
                hold = $urandom_range(10, 90);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= 16);
            end
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                mirror.compare_reply(rsp_if.status, rsp_if.hit_count);
                replies++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("ip_blocklist_table_unit_tb: errors");
        $finish;
    end

endmodule
